// ===== rtl/core/ssbpm_pkg.sv =====
package ssbpm_pkg;

  // Fixed build configuration
  localparam int unsigned FILTER_TAPS    = 63;
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned SINE_ADDR_BITS = 10;
  localparam int unsigned OUT_BITS       = 16;
  localparam int unsigned COEF_BITS      = 18;
  localparam int unsigned TapCentre      = (FILTER_TAPS - 1) / 2;
  localparam int unsigned LINE_AW        = $clog2(FILTER_TAPS);
  localparam int unsigned LINE_DEPTH     = 2 ** LINE_AW;
  localparam int unsigned QTAB_AW        = SINE_ADDR_BITS - 2;
  localparam int unsigned QTAB_DEPTH     = 2 ** QTAB_AW;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  // Fixed-point constants (Q30)
  localparam longint unsigned HalfPiQ30   = 64'd1686629713;
  localparam longint          TwoOverPiQ30 = 64'sd683565276;
  localparam longint          WinA0Q30     = 64'sd450971566;
  localparam longint          WinA2Q30     = 64'sd85899346;
  localparam longint          Q30One       = 64'sd1073741824;

  // Register map
  typedef enum logic [1:0] {
    REG_CARRIER_STEP   = 2'd0,
    REG_LOWER_SIDEBAND = 2'd1,
    REG_OUTPUT_GAIN    = 2'd2
  } reg_idx_e;

  localparam logic [15:0] GainReset = 16'd16384;

  // Count taps with an odd offset from the centre (the only non-zero ones)
  function automatic int unsigned count_nz();
    int unsigned cnt;
    int n;
    cnt = 0;
    for (int unsigned k = 0; k < FILTER_TAPS; k++) begin
      n = int'(k) - int'(TapCentre);
      if ((n % 2) != 0) cnt++;
    end
    return cnt;
  endfunction

  localparam int unsigned NZ_TAPS  = count_nz();
  localparam int unsigned TAP_AW   = $clog2(NZ_TAPS);
  localparam int unsigned SEL_BITS = $clog2(NZ_TAPS + 1);
  localparam int unsigned ACC_BITS = SAMPLE_BITS + COEF_BITS + TAP_AW;

  // Round to nearest, ties away from zero
  function automatic longint rnd_shift(longint v, int unsigned s);
    longint half;
    longint res;
    if (s == 0) begin
      res = v;
    end else begin
      half = longint'(1) <<< (s - 1);
      if (v >= 0) res = (v + half) >>> s;
      else        res = -((-v + half) >>> s);
    end
    return res;
  endfunction

  // Unsigned quotient by shift and subtract, for table building only
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine of a 32-bit phase in Q30, integer Taylor series
  function automatic longint sin_q30(logic [31:0] p);
    logic [1:0] quad;
    longint unsigned r, u, x, x2, term, d;
    longint sum;
    quad = p[31:30];
    r    = {34'd0, p[29:0]};
    u    = quad[0] ? ((64'd1 << 30) - r) : r;
    x    = (u * HalfPiQ30 + (64'd1 << 29)) >> 30;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    for (int unsigned k = 1; k <= 6; k++) begin
      d    = longint'(2 * k) * longint'(2 * k + 1);
      term = (term * x2 + (64'd1 << 29)) >> 30;
      term = udiv64(term + (d >> 1), d);
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum > Q30One) sum = Q30One;
    if (sum < 0)      sum = 0;
    return quad[1] ? -sum : sum;
  endfunction

  typedef logic [14:0] qtab_t [QTAB_DEPTH];

  // First quadrant of the sine table, Q0.15 magnitudes
  function automatic qtab_t build_qtab();
    qtab_t  tab;
    longint s;
    logic [31:0] p;
    for (int unsigned k = 0; k < QTAB_DEPTH; k++) begin
      p = 32'(k) << (32 - SINE_ADDR_BITS);
      s = rnd_shift(sin_q30(p), 15);
      if (s > 32767) s = 32767;
      tab[k] = s[14:0];
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // Full-turn sine read from the quarter table
  function automatic logic signed [15:0] sine_lookup(logic [SINE_ADDR_BITS-1:0] idx);
    logic [1:0]         quad;
    logic [QTAB_AW-1:0] r;
    logic [QTAB_AW-1:0] ridx;
    logic [14:0]        mag;
    quad = idx[SINE_ADDR_BITS-1 -: 2];
    r    = idx[QTAB_AW-1:0];
    ridx = quad[0] ? (QTAB_AW'(0) - r) : r;
    if (quad[0] && (r == '0)) mag = 15'd32767;
    else                      mag = QTAB[ridx];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  typedef logic signed [COEF_BITS-1:0] coef_tab_t [NZ_TAPS];
  typedef logic [LINE_AW-1:0]          age_tab_t  [NZ_TAPS];

  // Windowed Hilbert coefficients, Q1.17, non-zero taps only
  function automatic coef_tab_t build_coef();
    coef_tab_t tab;
    int unsigned j;
    int n;
    longint an, w, v, h;
    longint unsigned mag, d, den;
    logic [31:0] p1, p2;
    j   = 0;
    den = 64'(FILTER_TAPS - 1);
    for (int unsigned k = 0; k < FILTER_TAPS; k++) begin
      n  = int'(k) - int'(TapCentre);
      an = (n < 0) ? longint'(-n) : longint'(n);
      if (an[0]) begin
        p1  = 32'(udiv64((64'(k) << 32) + (den >> 1), den));
        p2  = 32'(udiv64((64'(2 * k) << 32) + (den >> 1), den));
        w   = WinA0Q30 - rnd_shift(sin_q30(p1 + 32'h4000_0000), 1)
              + rnd_shift(WinA2Q30 * sin_q30(p2 + 32'h4000_0000), 30);
        v   = rnd_shift(TwoOverPiQ30 * w, 30);
        mag = longint'((v < 0) ? -v : v);
        d   = longint'(an) << 13;
        h   = longint'(udiv64(mag + (d >> 1), d));
        if ((v < 0) != (n < 0)) h = -h;
        tab[j] = COEF_BITS'(h);
        j++;
      end
    end
    return tab;
  endfunction

  // Age (samples back from newest) of each non-zero tap
  function automatic age_tab_t build_age();
    age_tab_t tab;
    int unsigned j;
    int n;
    j = 0;
    for (int unsigned k = 0; k < FILTER_TAPS; k++) begin
      n = int'(k) - int'(TapCentre);
      if ((n % 2) != 0) begin
        tab[j] = LINE_AW'(k);
        j++;
      end
    end
    return tab;
  endfunction

  localparam coef_tab_t COEF_TAB = build_coef();
  localparam age_tab_t  AGE_TAB  = build_age();

  // Word handed from front to back
  typedef struct packed {
    logic [SINE_ADDR_BITS-1:0]     idx;
    logic signed [SAMPLE_BITS-1:0] sample;
  } q_item_t;

  typedef struct packed {
    logic                 valid;
    logic                 full;
    logic [QCNT_BITS-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic out_load;
  } bk_status_t;

endpackage

// ===== rtl/core/ssb_phasing_modulator_top.sv =====
// Channel   Dir  Handshake                 Word
// s_axis    in   tvalid/tready             tdata[15:0] audio_sample
// m_axis    out  tvalid/tready             tdata[15:0] rf_inphase, [31:16] rf_quadrature;
//                                          tuser clipped
// apb       in   psel/penable/pwrite/pready 0x0 carrier_step, 0x4 lower_sideband,
//                                          0x8 output_gain
//
// The back end works on one sample at a time, paced by the single delay-line read
// port: one non-zero tap per cycle, then the centre tap.
// A two-word queue lets the front take samples while the back end works.
// Reset (rst_ni low, asynchronous) clears phase, fill count, queue and output valid;
// unwritten delay-line entries read as zero through the fill count.
// A stalled output holds its word; the back end may start the next sample meanwhile.
module ssb_phasing_modulator_top
  import ssbpm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_BITS-1:0] s_axis_tdata,   // [15:0] audio_sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [2*OUT_BITS-1:0]  m_axis_tdata,   // [15:0] rf_inphase, [31:16] rf_quadrature
  output logic                   m_axis_tuser,   // [0] clipped
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [31:0] carrier_step_q;
  logic        lower_sideband_q;
  logic [15:0] output_gain_q;
  logic        cfg_we;
  reg_idx_e    cfg_idx;

  q_item_t    push_item, pop_item;
  logic       q_push, q_pop;
  q_status_t  q_status;
  bk_status_t bk_status;
  logic signed [OUT_BITS-1:0] out_i, out_q;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_step_q   <= '0;
      lower_sideband_q <= 1'b0;
      output_gain_q    <= GainReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CARRIER_STEP:   carrier_step_q   <= pwdata;
        REG_LOWER_SIDEBAND: lower_sideband_q <= pwdata[0];
        REG_OUTPUT_GAIN:    output_gain_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CARRIER_STEP:   prdata = carrier_step_q;
      REG_LOWER_SIDEBAND: prdata = {31'd0, lower_sideband_q};
      REG_OUTPUT_GAIN:    prdata = {16'd0, output_gain_q};
      default:            prdata = '0;
    endcase
  end

  ssbpm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_sample_i   (s_axis_tdata),
    .carrier_step_i(carrier_step_q),
    .q_full_i      (q_status.full),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  ssbpm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .item_o  (pop_item),
    .status_o(q_status)
  );

  ssbpm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_status.valid),
    .q_item_i        (pop_item),
    .q_pop_o         (q_pop),
    .lower_sideband_i(lower_sideband_q),
    .output_gain_i   (output_gain_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_inphase_o   (out_i),
    .out_quadrature_o(out_q),
    .out_clipped_o   (m_axis_tuser),
    .status_o        (bk_status)
  );

  assign m_axis_tdata = {out_q, out_i};

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_status.valid)
    else $error("back end popped an empty queue");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote an untaken word");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> bk_status.busy)
    else $error("back end not busy after taking a word");
`endif

endmodule

// ===== rtl/core/ssbpm_ram.sv =====
module ssbpm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ssbpm_front.sv =====
module ssbpm_front
  import ssbpm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  input  logic [31:0]            carrier_step_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output q_item_t                q_item_o
);

  logic [31:0] phase_q, phase_d;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Tag each word with the carrier phase it sees, then advance
  always_comb begin
    phase_d = phase_q;
    if (accept) phase_d = phase_q + carrier_step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  assign q_push_o        = accept;
  assign q_item_o.idx    = phase_q[31 -: SINE_ADDR_BITS];
  assign q_item_o.sample = $signed(in_sample_i);

endmodule

// ===== rtl/core/ssbpm_fifo.sv =====
module ssbpm_fifo
  import ssbpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_item_t   item_i,
  input  logic      pop_i,
  output q_item_t   item_o,
  output q_status_t status_o
);

  localparam int unsigned PtrBits = $clog2(QUEUE_DEPTH);

  q_item_t              mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;

  // Advance pointers and occupancy
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) wptr_d = (wptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    if (pop_i)  rptr_d = (rptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    if (push_i && !pop_i)      count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Hold queued words
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= item_i;
  end

  assign item_o         = mem_q[rptr_q];
  assign status_o.valid = (count_q != '0);
  assign status_o.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign status_o.count = count_q;

endmodule

// ===== rtl/core/ssbpm_back.sv =====
module ssbpm_back
  import ssbpm_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  q_item_t                    q_item_i,
  output logic                       q_pop_o,
  input  logic                       lower_sideband_i,
  input  logic [15:0]                output_gain_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OUT_BITS-1:0] out_inphase_o,
  output logic signed [OUT_BITS-1:0] out_quadrature_o,
  output logic                       out_clipped_o,
  output bk_status_t                 status_o
);

  localparam int unsigned PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned PI_BITS   = 2 * SAMPLE_BITS;
  localparam int unsigned PQ_BITS   = ACC_BITS + 16;
  localparam int unsigned MIX_BITS  = ACC_BITS + 16 + 2;
  localparam int unsigned RND_BITS  = MIX_BITS - 32;
  localparam int unsigned GP_BITS   = RND_BITS + 17;
  localparam int unsigned FILL_BITS = LINE_AW + 1;

  typedef enum logic [7:0] {
    BK_IDLE  = 8'b0000_0001,
    BK_ISSUE = 8'b0000_0010,
    BK_DRAIN = 8'b0000_0100,
    BK_PROD  = 8'b0000_1000,
    BK_SUM   = 8'b0001_0000,
    BK_RND   = 8'b0010_0000,
    BK_GAIN  = 8'b0100_0000,
    BK_EMIT  = 8'b1000_0000
  } bk_state_e;

  bk_state_e state_q, state_d;

  logic [LINE_AW-1:0]   wptr_q, wptr_d;
  logic [FILL_BITS-1:0] fill_q, fill_d;
  logic [SEL_BITS-1:0]  sel_q, sel_d;
  logic [TAP_AW-1:0]    tap_sel;
  logic [LINE_AW-1:0]   age;
  logic                 sel_last;

  logic                   ram_we, ram_re;
  logic [LINE_AW-1:0]     ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic                rd_vld_q, rd_last_q, rd_ok_q;
  logic [TAP_AW-1:0]   rd_sel_q;
  logic signed [SAMPLE_BITS-1:0] samp;

  logic signed [SAMPLE_BITS-1:0] ci_q;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic                          prod_vld_q, last2_q;
  logic signed [ACC_BITS-1:0]    acc_q;
  logic                          acc_clr;

  logic signed [15:0]         sin_q, cos_q;
  logic signed [PI_BITS-1:0]  pic_q, pis_q;
  logic signed [PQ_BITS-1:0]  pqs_q, pqc_q;
  logic signed [MIX_BITS-1:0] mi_q, mq_q, aic, ais;
  logic signed [RND_BITS-1:0] ri_q, rq_q;
  logic signed [GP_BITS-1:0]  gi_q, gq_q;

  logic                       out_vld_q, out_vld_d, out_load;
  logic signed [OUT_BITS-1:0] out_i_q, out_q_q, yi, yq;
  logic                       out_clip_q, clip_i, clip_q;

  // Saturate a rounded mix value to the output range
  function automatic logic signed [OUT_BITS-1:0] sat(longint v, output logic clip);
    logic signed [OUT_BITS-1:0] res;
    longint hi;
    longint lo;
    hi   = (longint'(1) <<< (OUT_BITS - 1)) - 1;
    lo   = -(longint'(1) <<< (OUT_BITS - 1));
    clip = 1'b0;
    if (v > hi) begin
      clip = 1'b1;
      res  = OUT_BITS'(hi);
    end else if (v < lo) begin
      clip = 1'b1;
      res  = OUT_BITS'(lo);
    end else begin
      res  = OUT_BITS'(v);
    end
    return res;
  endfunction

  assign tap_sel  = sel_q[TAP_AW-1:0];
  assign sel_last = (sel_q == SEL_BITS'(NZ_TAPS));
  assign age      = sel_last ? LINE_AW'(TapCentre) : AGE_TAB[tap_sel];
  assign out_load = (state_q == BK_EMIT) && (!out_vld_q || out_ready_i);

  // Sequencer: load sample, walk the taps, then mix, scale and emit
  always_comb begin
    state_d   = state_q;
    wptr_d    = wptr_q;
    fill_d    = fill_q;
    sel_d     = sel_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = wptr_q + 1'b1;
    ram_raddr = wptr_q - age;
    acc_clr   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ram_we  = 1'b1;
          acc_clr = 1'b1;
          wptr_d  = wptr_q + 1'b1;
          if (fill_q != FILL_BITS'(FILTER_TAPS)) fill_d = fill_q + 1'b1;
          sel_d   = '0;
          state_d = BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        ram_re = 1'b1;
        sel_d  = sel_q + 1'b1;
        if (sel_last) state_d = BK_DRAIN;
      end
      BK_DRAIN: if (last2_q) state_d = BK_PROD;
      BK_PROD:  state_d = BK_SUM;
      BK_SUM:   state_d = BK_RND;
      BK_RND:   state_d = BK_GAIN;
      BK_GAIN:  state_d = BK_EMIT;
      BK_EMIT:  if (out_load) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      wptr_q     <= '0;
      fill_q     <= '0;
      sel_q      <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      last2_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      wptr_q     <= wptr_d;
      fill_q     <= fill_d;
      sel_q      <= sel_d;
      rd_vld_q   <= ram_re;
      prod_vld_q <= rd_vld_q && !rd_last_q;
      last2_q    <= rd_vld_q && rd_last_q;
      out_vld_q  <= out_vld_d;
    end
  end

  // Delay line storage
  ssbpm_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(q_item_i.sample),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Tag each read; samples older than the fill count read as zero
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rd_last_q <= sel_last;
      rd_ok_q   <= (FILL_BITS'(age) < fill_q);
      rd_sel_q  <= tap_sel;
    end
  end

  assign samp = rd_ok_q ? $signed(ram_rdata) : '0;

  // Carrier lookup, multiply-accumulate path and centre capture
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      sin_q <= sine_lookup(q_item_i.idx);
      cos_q <= sine_lookup(q_item_i.idx + SINE_ADDR_BITS'(QTAB_DEPTH));
    end
    if (rd_vld_q && rd_last_q) ci_q <= samp;
    prod_q <= samp * COEF_TAB[rd_sel_q];
    if (acc_clr)         acc_q <= '0;
    else if (prod_vld_q) acc_q <= acc_q + ACC_BITS'(prod_q);
  end

  assign aic = MIX_BITS'(pic_q) <<< 17;
  assign ais = MIX_BITS'(pis_q) <<< 17;

  // Mix with the carrier, round, scale
  always_ff @(posedge clk_i) begin
    if (state_q == BK_PROD) begin
      pic_q <= ci_q * cos_q;
      pis_q <= ci_q * sin_q;
      pqs_q <= acc_q * sin_q;
      pqc_q <= acc_q * cos_q;
    end
    if (state_q == BK_SUM) begin
      if (lower_sideband_i) begin
        mi_q <= aic + MIX_BITS'(pqs_q);
        mq_q <= ais - MIX_BITS'(pqc_q);
      end else begin
        mi_q <= aic - MIX_BITS'(pqs_q);
        mq_q <= ais + MIX_BITS'(pqc_q);
      end
    end
    if (state_q == BK_RND) begin
      ri_q <= RND_BITS'(rnd_shift(longint'(mi_q), 32));
      rq_q <= RND_BITS'(rnd_shift(longint'(mq_q), 32));
    end
    if (state_q == BK_GAIN) begin
      gi_q <= ri_q * $signed({1'b0, output_gain_i});
      gq_q <= rq_q * $signed({1'b0, output_gain_i});
    end
  end

  always_comb begin
    yi = sat(rnd_shift(longint'(gi_q), 14), clip_i);
    yq = sat(rnd_shift(longint'(gq_q), 14), clip_q);
  end

  // Output register: hold until taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load)         out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_i_q    <= yi;
      out_q_q    <= yq;
      out_clip_q <= clip_i || clip_q;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign out_inphase_o     = out_i_q;
  assign out_quadrature_o  = out_q_q;
  assign out_clipped_o     = out_clip_q;
  assign status_o.busy     = (state_q != BK_IDLE);
  assign status_o.out_load = out_load;

endmodule

// ===== tb/sv/ssb_phasing_modulator_checker.sv =====
`timescale 1ns / 100ps

module ssb_phasing_modulator_checker
  import ssbpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          clipped_o
);

  localparam int Taps    = 63;
  localparam int Centre  = (Taps - 1) / 2;
  localparam int SineLen = 1024;

  typedef struct packed {
    logic signed [15:0] inph;
    logic signed [15:0] quad;
    logic               clip;
  } rf_word_t;

  longint    sine_lut [SineLen];
  longint    hilbert_coef [Taps];
  longint    audio_line [Taps];
  logic [31:0] phase_acc;
  logic [31:0] step_reg;
  logic        lsb_reg;
  logic [15:0] gain_reg;
  rf_word_t    rf_expected [$];

  // Round to nearest, ties away from zero
  function automatic longint round_shift(longint v, int s);
    longint half;
    if (s == 0) return v;
    half = longint'(1) <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  // Q30 sine of a full-turn 32-bit phase by integer Taylor series
  function automatic longint turn_sine_q30(logic [31:0] p);
    longint unsigned u, x, x2, term, d;
    longint sum;
    u    = p[30] ? ((64'd1 << 30) - {34'd0, p[29:0]}) : {34'd0, p[29:0]};
    x    = (u * 64'd1686629713 + (64'd1 << 29)) >> 30;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      d    = longint'(2 * k) * longint'(2 * k + 1);
      term = (term * x2 + (64'd1 << 29)) >> 30;
      term = (term + d / 2) / d;
      sum  = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
    end
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    if (sum < 0) sum = 0;
    return p[31] ? -sum : sum;
  endfunction

  function automatic longint clamp16(longint v, inout logic clip);
    if (v > 32767) begin clip = 1'b1; return 32767; end
    if (v < -32768) begin clip = 1'b1; return -32768; end
    return v;
  endfunction

  // Build the trig table and the windowed Hilbert taps
  initial begin
    longint s, w, v, h, mag, d;
    int n, an;
    logic [31:0] p1, p2;
    for (int k = 0; k < SineLen; k++) begin
      s = round_shift(turn_sine_q30(32'(k) << 22), 15);
      if (s > 32767) s = 32767;
      if (s < -32767) s = -32767;
      sine_lut[k] = s;
    end
    for (int k = 0; k < Taps; k++) begin
      n  = k - Centre;
      an = (n < 0) ? -n : n;
      if (an % 2 == 0) begin
        hilbert_coef[k] = 0;
      end else begin
        p1  = 32'(((longint'(k) <<< 32) + (Taps - 1) / 2) / (Taps - 1));
        p2  = 32'(((longint'(2 * k) <<< 32) + (Taps - 1) / 2) / (Taps - 1));
        w   = 64'sd450971566 - round_shift(turn_sine_q30(p1 + 32'h4000_0000), 1)
              + round_shift(64'sd85899346 * turn_sine_q30(p2 + 32'h4000_0000), 30);
        v   = round_shift(64'sd683565276 * w, 30);
        mag = (v < 0) ? -v : v;
        d   = longint'(an) <<< 13;
        h   = (mag + d / 2) / d;
        hilbert_coef[k] = ((v < 0) != (n < 0)) ? -h : h;
      end
    end
  end

  // Shift one sample in and work out the RF word it yields
  function automatic rf_word_t ssb_predict(logic signed [15:0] smp);
    rf_word_t r;
    longint aq, ai, sn, cs, mi, mq;
    logic [9:0] idx;
    logic clip;
    for (int k = Taps - 1; k > 0; k--) audio_line[k] = audio_line[k - 1];
    audio_line[0] = longint'(smp);
    aq = 0;
    for (int k = 0; k < Taps; k++) aq += hilbert_coef[k] * audio_line[k];
    ai  = audio_line[Centre] * 131072;
    idx = phase_acc[31:22];
    sn  = sine_lut[idx];
    cs  = sine_lut[10'(idx + 10'd256)];
    if (lsb_reg) begin
      mi = ai * cs + aq * sn;
      mq = ai * sn - aq * cs;
    end else begin
      mi = ai * cs - aq * sn;
      mq = ai * sn + aq * cs;
    end
    clip   = 1'b0;
    r.inph = 16'(clamp16(round_shift(round_shift(mi, 32) * longint'(gain_reg), 14), clip));
    r.quad = 16'(clamp16(round_shift(round_shift(mq, 32) * longint'(gain_reg), 14), clip));
    r.clip = clip;
    phase_acc = phase_acc + step_reg;
    return r;
  endfunction

  // Track registers, predict on each sample, compare each RF word
  always @(posedge clk_i or negedge rst_ni) begin
    rf_word_t want;
    if (!rst_ni) begin
      for (int k = 0; k < Taps; k++) audio_line[k] = 0;
      phase_acc    = '0;
      step_reg     = '0;
      lsb_reg      = 1'b0;
      gain_reg     = 16'd16384;
      rf_expected.delete();
      fail_count_o = 0;
      results_o    = 0;
      clipped_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          4'h0: step_reg = pwdata;
          4'h4: lsb_reg  = pwdata[0];
          4'h8: gain_reg = pwdata[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        if (rf_expected.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected RF word %h clip %b", m_axis_tdata, m_axis_tuser);
        end else begin
          want = rf_expected.pop_front();
          if (want.clip) clipped_o++;
          if (m_axis_tdata[15:0] !== want.inph || m_axis_tdata[31:16] !== want.quad ||
              m_axis_tuser !== want.clip) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("RF word %0d: I %0d/%0d Q %0d/%0d clip %b/%b (exp/act)",
                       results_o, want.inph, $signed(m_axis_tdata[15:0]), want.quad,
                       $signed(m_axis_tdata[31:16]), want.clip, m_axis_tuser);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want        = ssb_predict(s_axis_tdata);
        rf_expected = {rf_expected, want};
      end
    end
    pending_o = rf_expected.size();
  end

endmodule

// ===== tb/sv/ssb_phasing_modulator_top_tb.sv =====
`timescale 1ns / 100ps

module ssb_phasing_modulator_top_tb;
  import ssbpm_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] audio_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [15:0] rf_inphase, [31:16] rf_quadrature
  logic        m_axis_tuser;        // [0] clipped
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, results, clipped;
  int          sent;
  int          stall_mode = 0;

  always #10 clk_i = ~clk_i;

  ssb_phasing_modulator_top u_dut (.*);

  ssb_phasing_modulator_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .clipped_o(clipped)
  );

  // Stall the output on a randomly chosen pattern that changes from time to time
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) stall_mode <= int'($urandom_range(0, 2));
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Present one word from the current edge, hold it until taken; optionally drop valid
  task automatic send_sample(logic [15:0] smp, int gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    sent++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Let the block drain before touching registers
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_burst(int count, bit loud);
    int left, burst;
    logic [15:0] smp;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && left > 0; b++) begin
        if (loud)                          smp = 16'($urandom);
        else if ($urandom_range(0, 3) == 0) smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        else                               smp = 16'($signed($urandom_range(0, 8191)) - 4096);
        send_sample(smp, (b == burst - 1 || left == 1) ? $urandom_range(0, 90) : 0);
        left--;
      end
    end
  endtask

  initial begin
    sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes and impulses at reset settings, then extremes with a new step and an unmapped write
    send_sample(16'h7FFF, 0);
    send_sample(16'h8000, 0);
    send_sample(16'h0000, 0);
    send_sample(16'h0001, 3);
    send_sample(16'hFFFF, 0);
    for (int k = 0; k < 8; k++) send_sample(16'h8000, 0);
    drain();
    reg_write(4'h0, 32'h0400_0000);
    reg_write(4'hC, 32'hFFFF_FFFF);
    for (int k = 0; k < 10; k++) send_sample(k % 2 ? 16'h7FFF : 16'h8000, 0);
    drain();

    // Lower sideband at full gain, forcing saturation
    reg_write(4'h4, 32'hFFFF_FFFF);
    reg_write(4'h8, 32'hFFFF_FFFF);
    random_burst(250, 1'b1);
    drain();

    // Upper sideband, gain zero, top step
    reg_write(4'h4, 32'h0000_0002);
    reg_write(4'h8, 32'h0000_0000);
    reg_write(4'h0, 32'hFFFF_FFFF);
    random_burst(150, 1'b0);
    drain();

    // Random settings for the rest
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(4'h0, $urandom);
      reg_write(4'h4, $urandom);
      reg_write(4'h8, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(8192, 24576));
      random_burst(190, ph % 2);
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("Sent %0d samples over several register settings, checked %0d RF words",
             sent, results);
    $display("Words that saturated: %0d", clipped);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout with %0d words outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
